// ----- rtl/quantized_mesh_stream_decoder_macros.svh -----
// Assertion macros for the terrain mesh stream decoder.
`ifndef QUANTIZED_MESH_STREAM_DECODER_MACROS_SVH
`define QUANTIZED_MESH_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define QMSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define QMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/qmsd_pkg.sv -----
// Shared types, codes and helpers for the terrain mesh stream decoder.
package qmsd_pkg;

  localparam int CMD_W   = 3;
  localparam int CODE_W  = 32;
  localparam int COORD_W = 16;
  localparam int CHAN_W  = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_U      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_V      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_HEIGHT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_INDEX  = 3'd4;

  localparam logic [CHAN_W-1:0] CH_U      = 2'd0;
  localparam logic [CHAN_W-1:0] CH_V      = 2'd1;
  localparam logic [CHAN_W-1:0] CH_HEIGHT = 2'd2;
  localparam logic [CHAN_W-1:0] CH_INDEX  = 2'd3;

  localparam logic [1:0] CORNER_FIRST  = 2'd0;
  localparam logic [1:0] CORNER_SECOND = 2'd1;
  localparam logic [1:0] CORNER_THIRD  = 2'd2;

  typedef struct packed {
    logic fire;
    logic clear;
  } idx_ctl_t;

  function automatic logic [COORD_W-1:0] zigzag16(input logic [CODE_W-1:0] code);
    logic [COORD_W-1:0] w;
    w = code[COORD_W-1:0];
    return (w >> 1) ^ {COORD_W{w[0]}};
  endfunction

endpackage

// ----- rtl/quantized_mesh_stream_decoder.sv -----
// Terrain mesh stream decoder top level: vertex delta sums and triangle indices.
// Beats pass the input register, then the result register; an empty input register
// fills while a result waits. Throughput: one beat per cycle while out_stall is low.
// Clear and unused commands pass the input register without a result slot.
// Reset (rst_n, synchronous): clears all sums, the index state and both valid bits.
module quantized_mesh_stream_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [qmsd_pkg::CMD_W-1:0]   in_command,
  input  logic [qmsd_pkg::CODE_W-1:0]  in_code,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [qmsd_pkg::CODE_W-1:0]  out_value,
  output logic [qmsd_pkg::CHAN_W-1:0]  out_channel,
  output logic                         out_triangle_done,
  output logic                         out_degenerate
);
  import qmsd_pkg::*;

  logic              in_valid_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [CODE_W-1:0] code_r;

  logic [COORD_W-1:0] u_r, v_r, h_r;
  logic [COORD_W-1:0] sum_nxt, sel_sum;

  logic              out_valid_r;
  logic [CODE_W-1:0] value_r, value_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic              done_r, done_nxt;
  logic              degen_r, degen_nxt;

  logic              is_vertex, is_index, has_result, adv;
  idx_ctl_t          idx_ctl;
  logic [CODE_W-1:0] idx;
  logic              idx_done, idx_degen;

  assign is_vertex  = (cmd_r == CMD_U) || (cmd_r == CMD_V) || (cmd_r == CMD_HEIGHT);
  assign is_index   = (cmd_r == CMD_INDEX);
  assign has_result = is_vertex || is_index;
  assign adv        = in_valid_r && (!has_result || !out_valid_r || !out_stall);
  assign in_stall   = in_valid_r && !adv;

  assign idx_ctl.fire  = adv && is_index;
  assign idx_ctl.clear = adv && (cmd_r == CMD_CLEAR);

  qmsd_index_dec u_idx (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (idx_ctl),
    .code  (code_r),
    .idx   (idx),
    .done  (idx_done),
    .degen (idx_degen)
  );

  always_comb begin
    case (cmd_r)
      CMD_U:   sel_sum = u_r;
      CMD_V:   sel_sum = v_r;
      default: sel_sum = h_r;
    endcase
    sum_nxt = sel_sum + zigzag16(code_r);
    if (is_index) begin
      value_nxt = idx;
      chan_nxt  = CH_INDEX;
      done_nxt  = idx_done;
      degen_nxt = idx_degen;
    end else begin
      value_nxt = {{(CODE_W-COORD_W){1'b0}}, sum_nxt};
      chan_nxt  = cmd_r[CHAN_W-1:0] - 1'b1;
      done_nxt  = 1'b0;
      degen_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_r  <= in_command;
      code_r <= in_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || idx_ctl.clear) begin
      u_r <= '0;
      v_r <= '0;
      h_r <= '0;
    end else if (adv) begin
      case (cmd_r)
        CMD_U:      u_r <= sum_nxt;
        CMD_V:      v_r <= sum_nxt;
        CMD_HEIGHT: h_r <= sum_nxt;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && has_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_result) begin
      value_r <= value_nxt;
      chan_r  <= chan_nxt;
      done_r  <= done_nxt;
      degen_r <= degen_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_value         = value_r;
  assign out_channel       = chan_r;
  assign out_triangle_done = done_r;
  assign out_degenerate    = degen_r;

`include "quantized_mesh_stream_decoder_macros.svh"

  `QMSD_ASSERT_IMPL(a_vertex_flags, out_valid && (out_channel != CH_INDEX), !out_triangle_done && !out_degenerate, "vertex beat carries triangle flags")
  `QMSD_ASSERT_IMPL(a_degen_done, out_valid && out_degenerate, out_triangle_done, "degenerate without triangle done")
  `QMSD_ASSERT_NEXT(a_in_capture, in_valid && !in_stall, in_valid_r, "accepted beat not held in input register")
  `QMSD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_value), "stalled result lost")

endmodule

// ----- rtl/qmsd_index_dec.sv -----
// High-water-mark triangle index decoder with corner tracking.
module qmsd_index_dec (
  input  logic                       clk,
  input  logic                       rst_n,
  input  qmsd_pkg::idx_ctl_t         ctl,
  input  logic [qmsd_pkg::CODE_W-1:0] code,
  output logic [qmsd_pkg::CODE_W-1:0] idx,
  output logic                       done,
  output logic                       degen
);
  import qmsd_pkg::*;

  logic [CODE_W-1:0] highest_r, highest_nxt;
  logic [CODE_W-1:0] first_r, first_nxt;
  logic [CODE_W-1:0] second_r, second_nxt;
  logic [1:0]        corner_r, corner_nxt;

  assign idx = highest_r - code;

  always_comb begin
    highest_nxt = highest_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    corner_nxt  = corner_r;
    done        = 1'b0;
    degen       = 1'b0;
    case (corner_r)
      CORNER_FIRST: begin
        first_nxt  = idx;
        corner_nxt = CORNER_SECOND;
      end
      CORNER_SECOND: begin
        second_nxt = idx;
        corner_nxt = CORNER_THIRD;
      end
      default: begin
        done       = 1'b1;
        degen      = (first_r == second_r) || (second_r == idx) || (first_r == idx);
        corner_nxt = CORNER_FIRST;
      end
    endcase
    if (code == '0) begin
      highest_nxt = highest_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      highest_r <= '0;
      first_r   <= '0;
      second_r  <= '0;
      corner_r  <= CORNER_FIRST;
    end else if (ctl.fire) begin
      highest_r <= highest_nxt;
      first_r   <= first_nxt;
      second_r  <= second_nxt;
      corner_r  <= corner_nxt;
    end
  end

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the terrain mesh stream decoder.
`timescale 1ns / 100ps

import qmsd_pkg::*;

class mesh_scoreboard;
  typedef struct {
    logic [CODE_W-1:0] value;
    logic [CHAN_W-1:0] channel;
    logic              tri_done;
    logic              degen;
  } decoded_beat_t;

  decoded_beat_t      decoded_q[$];
  logic [COORD_W-1:0] coord_sum[3];
  logic [CODE_W-1:0]  high_water;
  logic [1:0]         corner;
  logic [CODE_W-1:0]  corner_a;
  logic [CODE_W-1:0]  corner_b;

  int mismatches;
  int results_checked;
  int vertex_beats;
  int index_beats;
  int clear_beats;
  int unused_beats;
  int triangles;
  int degenerates;

  function new();
    clear_tile();
  endfunction

  function void clear_tile();
    foreach (coord_sum[i]) coord_sum[i] = '0;
    high_water = '0;
    corner     = CORNER_FIRST;
    corner_a   = '0;
    corner_b   = '0;
  endfunction

  function void note_input(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code);
    decoded_beat_t      r;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] delta;
    logic [CODE_W-1:0]  idx;
    r.value    = '0;
    r.channel  = CH_U;
    r.tri_done = 1'b0;
    r.degen    = 1'b0;
    w     = code[COORD_W-1:0];
    delta = {1'b0, w[COORD_W-1:1]} ^ {COORD_W{w[0]}};
    case (cmd)
      CMD_CLEAR: begin
        clear_beats++;
        clear_tile();
      end
      CMD_U, CMD_V, CMD_HEIGHT: begin
        vertex_beats++;
        r.channel = (cmd == CMD_U) ? CH_U : (cmd == CMD_V) ? CH_V : CH_HEIGHT;
        coord_sum[r.channel] = coord_sum[r.channel] + delta;
        r.value = {{(CODE_W-COORD_W){1'b0}}, coord_sum[r.channel]};
        decoded_q = {decoded_q, r};
      end
      CMD_INDEX: begin
        index_beats++;
        idx = high_water - code;
        if (code == '0) high_water = high_water + 1;
        case (corner)
          CORNER_FIRST: begin
            corner_a = idx;
            corner   = CORNER_SECOND;
          end
          CORNER_SECOND: begin
            corner_b = idx;
            corner   = CORNER_THIRD;
          end
          default: begin
            r.tri_done = 1'b1;
            r.degen    = (corner_a == corner_b) || (corner_b == idx) || (corner_a == idx);
            corner     = CORNER_FIRST;
          end
        endcase
        r.value   = idx;
        r.channel = CH_INDEX;
        decoded_q = {decoded_q, r};
      end
      default: unused_beats++;
    endcase
  endfunction

  function void check_result(input logic [CODE_W-1:0] value, input logic [CHAN_W-1:0] channel,
                             input logic tri_done, input logic degen);
    decoded_beat_t e;
    results_checked++;
    if (decoded_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result beat value=%h chan=%0d done=%b degen=%b",
                 $realtime, value, channel, tri_done, degen);
      return;
    end
    e = decoded_q.pop_front();
    if (e.tri_done) triangles++;
    if (e.degen) degenerates++;
    if (value !== e.value || channel !== e.channel || tri_done !== e.tri_done ||
        degen !== e.degen) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch exp value=%h chan=%0d done=%b degen=%b, got value=%h chan=%0d done=%b degen=%b",
                 $realtime, e.value, e.channel, e.tri_done, e.degen,
                 value, channel, tri_done, degen);
    end
  endfunction

  function int pending();
    return decoded_q.size();
  endfunction

  function void flag_leftover();
    if (decoded_q.size() != 0) begin
      mismatches += decoded_q.size();
      $display("%0d result beats never arrived", decoded_q.size());
    end
  endfunction
endclass

module testbench;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_INDEX + 1;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;
  localparam int RANDOM_BEATS = 1200;

  typedef enum int { STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE, STALL_LONG } stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_command = '0;
  logic [CODE_W-1:0] in_code = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CODE_W-1:0] out_value;
  logic [CHAN_W-1:0] out_channel;
  logic              out_triangle_done;
  logic              out_degenerate;

  mesh_scoreboard sb;
  int             burst_left = 0;
  int             stall_left = 0;
  stall_mode_t    stall_mode = STALL_NONE;

  quantized_mesh_stream_decoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_code           (in_code),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .out_channel       (out_channel),
    .out_triangle_done (out_triangle_done),
    .out_degenerate    (out_degenerate)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_value, out_channel, out_triangle_done, out_degenerate);
      if (in_valid && !in_stall)
        sb.note_input(in_command, in_code);
    end
  end

  // receiver back-pressure, with a stall mode picked at random anew each time its countdown runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_LONG));
      stall_left = $urandom_range(32, 256);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
      STALL_TOGGLE: out_stall <= stall_left[1];
      default:      out_stall <= stall_left[3];
    endcase
  end

  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code);
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_code    <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 16);
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_directed();
    send_beat(CMD_CLEAR, 32'h0);
    send_beat(CMD_U, 32'h0000_0000);
    send_beat(CMD_U, 32'h0000_0001);
    send_beat(CMD_U, 32'h0000_FFFF);
    send_beat(CMD_U, 32'h0000_FFFE);
    send_beat(CMD_V, 32'hABCD_0003);
    send_beat(CMD_HEIGHT, 32'hFFFF_FFFF);
    send_beat(CMD_HEIGHT, 32'h0000_FFFE);
    send_beat(CMD_INDEX, 32'h0000_0000);
    send_beat(CMD_INDEX, 32'h0000_0000);
    send_beat(CMD_INDEX, 32'hFFFF_FFFF);
    send_beat(CMD_INDEX, 32'h0000_0001);
    send_beat(CMD_INDEX, 32'h0000_0000);
    send_beat(CMD_INDEX, 32'h0000_0002);
    send_beat(CMD_INDEX, 32'h0000_0000);
    send_beat(CMD_CLEAR, 32'hFFFF_FFFF);
    send_beat(CMD_INDEX, 32'h0000_0000);
    send_beat(CMD_INDEX, 32'h0000_0001);
    send_beat(CMD_INDEX, 32'h0000_0001);
    send_beat(CMD_INDEX, 32'h8000_0000);
    send_beat(CMD_UNUSED_LO, 32'h0000_0000);
    send_beat(CMD_UNUSED_HI, 32'hFFFF_FFFF);
    send_beat(CMD_INDEX, 32'h0000_0000);
    send_beat(CMD_INDEX, 32'h0000_0000);
  endtask

  task automatic send_random();
    int               counted;
    int               sel;
    logic [CMD_W-1:0] cmd;
    logic [CODE_W-1:0] code;
    counted = 0;
    while (counted < RANDOM_BEATS) begin
      sel  = $urandom_range(0, 99);
      code = $urandom();
      if (sel < 2) begin
        cmd = CMD_CLEAR;
        counted++;
      end else if (sel < 5) begin
        cmd = CMD_UNUSED_LO + $urandom_range(0, CMD_UNUSED_HI - CMD_UNUSED_LO);
      end else if (sel < 45) begin
        cmd = CMD_U + $urandom_range(0, CMD_HEIGHT - CMD_U);
        if ($urandom_range(0, 9) < 7)
          code[COORD_W-1:0] = $urandom_range(0, 63);
        counted++;
      end else begin
        cmd = CMD_INDEX;
        sel = $urandom_range(0, 99);
        if (sel < 55) code = '0;
        else if (sel < 85) code = $urandom_range(1, 4);
        counted++;
      end
      send_beat(cmd, code);
    end
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    send_random();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    sb.flag_leftover();
    $display("Sent %0d vertex, %0d index, %0d clear and %0d unused-command beats.",
             sb.vertex_beats, sb.index_beats, sb.clear_beats, sb.unused_beats);
    $display("Checked %0d results: %0d triangles, %0d degenerate; %0d mismatches.",
             sb.results_checked, sb.triangles, sb.degenerates, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
